// ----- sv/smvf_pkg.sv -----
package smvf_pkg;

    // Fixed widths of the word and of the fields of one operation and one result.
    localparam int WORD_W   = 32;
    localparam int OP_W     = 4;
    localparam int IDX_W    = 4;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_VAL = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_VAR = 4'd1;
    localparam logic [OP_W-1:0] OP_DROP     = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_VAR  = 4'd3;
    localparam logic [OP_W-1:0] OP_PEEK_VAR = 4'd4;
    localparam logic [OP_W-1:0] OP_DUP      = 4'd5;
    localparam logic [OP_W-1:0] OP_ADD      = 4'd6;
    localparam logic [OP_W-1:0] OP_SUB      = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd9;
    localparam logic [OP_W-1:0] OP_EQ       = 4'd10;
    localparam logic [OP_W-1:0] OP_GT       = 4'd11;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd12;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;

    // One operation word.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
        logic [IDX_W-1:0]         var_index;
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     flag;
        logic [DEPTH_W-1:0]       stack_depth;
        logic [STATUS_W-1:0]      status;
    } t_rsp;

    // Shift control shared by every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

// ----- sv/smvf_if.sv -----
interface smvf_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- sv/smvf_cell.sv -----
module smvf_cell (
    input  logic                        i_clk,
    input  smvf_pkg::t_stack_ctl        i_ctl,
    input  logic [smvf_pkg::WORD_W-1:0] i_up,
    input  logic [smvf_pkg::WORD_W-1:0] i_down,
    output logic [smvf_pkg::WORD_W-1:0] o_word
);

    logic [smvf_pkg::WORD_W-1:0] r_word;

    // A push takes the entry from the cell above, a pop the one from below.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_word <= i_up;
        end else if (i_ctl.pop) begin
            r_word <= i_down;
        end
    end

    assign o_word = r_word;

endmodule

// ----- sv/smvf_div.sv -----
module smvf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smvf_pkg::WORD_W-1:0] i_num,
    input  logic [smvf_pkg::WORD_W-1:0] i_den,
    output logic                        o_busy,
    output logic [smvf_pkg::WORD_W-1:0] o_quot
);

    localparam int W  = smvf_pkg::WORD_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // Unsigned magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;

endmodule

// ----- sv/stack_machine_with_variable_file.sv -----
// Stack machine with a variable file. Each accepted operation word yields exactly one
// result word. Most operations first latch the operation and read the variable memory,
// then evaluate and commit. A multiply adds a step for its registered product, and a
// divide adds a step to start the bit-serial restoring divider and then waits for its
// 32 quotient bits before the commit. Operations are handled one at a time; a new word
// is accepted while the previous result still waits in the output register, and the
// commit holds until that register is free. The operand stack is a chain of
// STACK_DEPTH cells that shift down on a push and up on a pop, so the top two entries
// are always in the first two cells. No clearing pass follows reset.
module stack_machine_with_variable_file #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    smvf_if.sink           i_cmd,
    smvf_if.source         o_rsp
);

    localparam int W  = smvf_pkg::WORD_W;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP,
        ACT_CLEAR
    } t_act;

    t_state r_state;
    t_state n_state;

    logic [smvf_pkg::OP_W-1:0] r_op;
    logic [W-1:0]              r_value;
    logic [VW-1:0]             r_addr;
    logic                      r_vok;
    logic [PW-1:0]             r_sp;
    logic [PW-1:0]             n_sp;
    logic [VAR_COUNT-1:0]      r_var_valid;
    logic [W-1:0]              r_var_mem [VAR_COUNT];
    logic [W-1:0]              r_var_rd;
    logic [W-1:0]              r_prod;
    logic                      r_neg;
    logic                      r_out_valid;
    smvf_pkg::t_rsp            r_out;

    logic                      w_acc;
    logic                      w_slot;
    logic                      w_commit;
    logic [W-1:0]              w_top;
    logic [W-1:0]              w_second;
    logic                      w_empty;
    logic                      w_lt2;
    logic                      w_full;

    logic [smvf_pkg::STATUS_W-1:0] d_status;
    logic [W-1:0]              d_res;
    logic                      d_flag;
    t_act                      d_act;
    logic                      d_var_wr;
    logic                      d_mul;
    logic                      d_div;

    logic [W-1:0]              c_res;
    t_act                      c_act;
    logic [smvf_pkg::STATUS_W-1:0] c_status;
    logic                      c_flag;
    logic                      c_var_wr;

    logic                      w_div_start;
    logic                      w_div_busy;
    logic [W-1:0]              w_div_quot;
    logic [W-1:0]              w_quot_fix;
    logic [W-1:0]              w_mag_top;
    logic [W-1:0]              w_mag_second;

    smvf_pkg::t_stack_ctl      w_ctl;
    logic [W-1:0]              w_cell [STACK_DEPTH];
    logic [W-1:0]              w_up   [STACK_DEPTH];
    logic [W-1:0]              w_down [STACK_DEPTH];

    // Handshake on both sides.
    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_slot      = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload = r_out;

    // Latch the operation word.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op    <= i_cmd.payload.op;
            r_value <= i_cmd.payload.value;
            r_addr  <= VW'(i_cmd.payload.var_index);
            r_vok   <= (32'(i_cmd.payload.var_index) < 32'(VAR_COUNT));
        end
    end

    // Variable memory: registered read at acceptance, write on commit.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_var_rd <= r_var_mem[VW'(i_cmd.payload.var_index)];
        end
        if (w_commit && c_var_wr) begin
            r_var_mem[r_addr] <= w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_valid <= '0;
        end else if (w_commit && c_var_wr) begin
            r_var_valid[r_addr] <= 1'b1;
        end
    end

    // Chain of stack cells; cell zero holds the top entry.
    assign w_ctl.push = w_commit && (c_act == ACT_PUSH);
    assign w_ctl.pop  = w_commit && (c_act == ACT_POP);

    generate
        for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_up[g] = c_res;
            end else begin : g_inner
                assign w_up[g] = w_cell[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign w_down[g] = w_cell[g];
            end else begin : g_body
                assign w_down[g] = w_cell[g+1];
            end
            smvf_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_up   (w_up[g]),
                .i_down (w_down[g]),
                .o_word (w_cell[g])
            );
        end
    endgenerate

    assign w_top    = w_cell[0];
    assign w_second = w_cell[1];
    assign w_empty  = (r_sp == '0);
    assign w_lt2    = (r_sp < PW'(2));
    assign w_full   = (r_sp >= PW'(STACK_DEPTH));

    // Evaluate the latched operation against the stack and variable state.
    always_comb begin
        d_status = smvf_pkg::ST_OK;
        d_res    = '0;
        d_flag   = 1'b0;
        d_act    = ACT_NONE;
        d_var_wr = 1'b0;
        d_mul    = 1'b0;
        d_div    = 1'b0;
        unique case (r_op)
            smvf_pkg::OP_PUSH_VAL: begin
                if (w_full) begin
                    d_status = smvf_pkg::ST_OVERFLOW;
                end else begin
                    d_res = r_value;
                    d_act = ACT_PUSH;
                end
            end
            smvf_pkg::OP_PUSH_VAR: begin
                if (!r_vok || !r_var_valid[r_addr]) begin
                    d_status = smvf_pkg::ST_UNKNOWN;
                end else if (w_full) begin
                    d_status = smvf_pkg::ST_OVERFLOW;
                end else begin
                    d_res = r_var_rd;
                    d_act = ACT_PUSH;
                end
            end
            smvf_pkg::OP_DROP: begin
                if (w_empty) begin
                    d_status = smvf_pkg::ST_UNDERFLOW;
                end else begin
                    d_res = w_top;
                    d_act = ACT_POP;
                end
            end
            smvf_pkg::OP_POP_VAR, smvf_pkg::OP_PEEK_VAR: begin
                if (!r_vok) begin
                    d_status = smvf_pkg::ST_UNKNOWN;
                end else if (w_empty) begin
                    d_status = smvf_pkg::ST_UNDERFLOW;
                end else begin
                    d_res    = w_top;
                    d_var_wr = 1'b1;
                    d_act    = (r_op == smvf_pkg::OP_POP_VAR) ? ACT_POP : ACT_NONE;
                end
            end
            smvf_pkg::OP_DUP: begin
                if (w_empty) begin
                    d_status = smvf_pkg::ST_UNDERFLOW;
                end else if (w_full) begin
                    d_status = smvf_pkg::ST_OVERFLOW;
                end else begin
                    d_res = w_top;
                    d_act = ACT_PUSH;
                end
            end
            smvf_pkg::OP_ADD, smvf_pkg::OP_SUB, smvf_pkg::OP_MUL, smvf_pkg::OP_DIV: begin
                if (w_lt2) begin
                    d_status = smvf_pkg::ST_UNDERFLOW;
                end else if (w_full) begin
                    d_status = smvf_pkg::ST_OVERFLOW;
                end else if (r_op == smvf_pkg::OP_DIV && w_second == '0) begin
                    d_status = smvf_pkg::ST_DIVZERO;
                end else begin
                    d_act = ACT_PUSH;
                    d_mul = (r_op == smvf_pkg::OP_MUL);
                    d_div = (r_op == smvf_pkg::OP_DIV);
                    d_res = (r_op == smvf_pkg::OP_ADD) ? (w_top + w_second)
                                                       : (w_top - w_second);
                end
            end
            smvf_pkg::OP_EQ, smvf_pkg::OP_GT: begin
                if (w_lt2) begin
                    d_status = smvf_pkg::ST_UNDERFLOW;
                end else if (r_op == smvf_pkg::OP_EQ) begin
                    d_flag = (w_top == w_second);
                end else begin
                    d_flag = ($signed(w_top) > $signed(w_second));
                end
            end
            smvf_pkg::OP_CLEAR: begin
                d_act = ACT_CLEAR;
            end
            default: begin
                d_act = ACT_NONE;
            end
        endcase
    end

    // Multiplier, registered before the commit.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_prod <= w_top * w_second;
        end
    end

    // Divider on magnitudes, sign applied to the quotient afterwards.
    assign w_div_start  = (r_state == S_EXEC) && d_div;
    assign w_mag_top    = w_top[W-1] ? (~w_top + W'(1)) : w_top;
    assign w_mag_second = w_second[W-1] ? (~w_second + W'(1)) : w_second;

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_neg <= w_top[W-1] ^ w_second[W-1];
        end
    end

    smvf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mag_top),
        .i_den   (w_mag_second),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    assign w_quot_fix = r_neg ? (~w_div_quot + W'(1)) : w_div_quot;

    // Select what is committed in the current state.
    always_comb begin
        c_res    = d_res;
        c_act    = ACT_PUSH;
        c_status = smvf_pkg::ST_OK;
        c_flag   = 1'b0;
        c_var_wr = 1'b0;
        priority if (r_state == S_MUL) begin
            c_res = r_prod;
        end else if (r_state == S_DIV) begin
            c_res = w_quot_fix;
        end else begin
            c_act    = d_act;
            c_status = d_status;
            c_flag   = d_flag;
            c_var_wr = d_var_wr;
        end
    end

    assign w_commit = w_slot && (((r_state == S_EXEC) && !d_mul && !d_div) ||
                                 (r_state == S_MUL) ||
                                 ((r_state == S_DIV) && !w_div_busy));

    // Stack pointer after the committed operation.
    always_comb begin
        n_sp = r_sp;
        if (w_commit) begin
            unique case (c_act)
                ACT_PUSH:  n_sp = r_sp + PW'(1);
                ACT_POP:   n_sp = r_sp - PW'(1);
                ACT_CLEAR: n_sp = '0;
                ACT_NONE:  n_sp = r_sp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            r_sp <= n_sp;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (d_mul) begin
                    n_state = S_MUL;
                end else if (d_div) begin
                    n_state = S_DIV;
                end else if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (!w_div_busy && w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register holds one result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.result_value <= c_res;
            r_out.flag         <= c_flag;
            r_out.stack_depth  <= smvf_pkg::DEPTH_W'(n_sp);
            r_out.status       <= c_status;
        end
    end

`ifndef SYNTH
    // The stack pointer never passes the stack size.
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond stack size");

    // A push is committed only when the stack has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |-> (r_sp < PW'(STACK_DEPTH)))
        else $error("push committed on a full stack");

    // An accepted word is evaluated in the next cycle.
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_EXEC))
        else $error("accepted word not evaluated");

    // The divider is busy just after a divide is started.
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> w_div_busy)
        else $error("divider did not start");
`endif

endmodule
